>>> hdl/stb_pkg.sv
`default_nettype none

package stb_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_RESERVED  = 3'd1,
    ST_CLIMATE   = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  // Single-precision bit patterns bounding an acceptable climate value.
  localparam logic [31:0] ONE_BITS      = 32'h3F80_0000;
  localparam logic [31:0] NEG_ZERO_BITS = 32'h8000_0000;

  // One input request.
  typedef struct packed {
    logic        has_entry;
    logic [15:0] tile_x;
    logic [15:0] tile_y;
    logic [31:0] reserved_word;
    logic [31:0] climate_a;
    logic [31:0] climate_b;
    logic [31:0] climate_c;
    logic [31:0] climate_d;
    logic        last_item;
  } item_t;

  // One result request.
  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  entry_count;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [31:0] out_climate_a;
    logic [31:0] out_climate_b;
    logic [31:0] out_climate_c;
    logic [31:0] out_climate_d;
    logic        entry_valid;
    logic        last_result;
  } result_t;

  // One stored table entry: key is column in the upper half, row in the lower.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] ca;
    logic [31:0] cb;
    logic [31:0] cc;
    logic [31:0] cd;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_item;
    logic    fill_inc;
    logic    set_err;
    status_t err_code;
    logic    pos_load;
    logic    pos_dec;
    logic    rd_prev;
    logic    wr_shift;
    logic    wr_new;
    logic    emit_start;
    logic    emit_rd;
    logic    emit_inc;
    logic    load_entry;
    logic    load_status;
    logic    clear_set;
  } cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic has_entry;
    logic last_item;
    logic full;
    logic err_set;
    logic rsv_bad;
    logic clim_bad;
    logic fill_zero;
    logic pos_one;
    logic cmp_gt;
    logic cmp_eq;
    logic emit_last;
    logic out_free;
  } sts_t;

  // A climate word passes if it is negative zero or a finite value from 0 to 1.
  function automatic logic climate_ok(input logic [31:0] bits);
    climate_ok = (bits == NEG_ZERO_BITS) || (bits <= ONE_BITS);
  endfunction

endpackage

`default_nettype wire

>>> hdl/stb_datapath.sv
`default_nettype none

module stb_datapath
  import stb_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire item_t   in_data,
  input  wire cmd_t    cmd,
  output sts_t         sts,
  input  wire logic    out_ready,
  output logic         out_valid,
  output result_t      out_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = $clog2(TABLE_DEPTH + 1);

  item_t          item;
  logic [FW-1:0]  fill;
  status_t        error;
  logic [AW-1:0]  pos;
  logic [AW-1:0]  idx;
  entry_t         mem [TABLE_DEPTH];
  entry_t         rdata;
  entry_t         new_entry;
  logic [AW-1:0]  rd_addr;
  logic [31:0]    key;

  // The record under insertion, packed as a table entry.
  assign key       = {item.tile_x, item.tile_y};
  assign new_entry = '{key: key, ca: item.climate_a, cb: item.climate_b,
                       cc: item.climate_c, cd: item.climate_d};

  // The single read port serves either the insertion scan or the emission.
  assign rd_addr = cmd.emit_rd ? idx : pos - AW'(1);

  // Set-level control state and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      error     <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_set) begin
        fill  <= '0;
        error <= ST_OK;
      end else begin
        if (cmd.fill_inc) begin
          fill <= fill + FW'(1);
        end
        if (cmd.set_err) begin
          error <= cmd.err_code;
        end
      end
      if (cmd.load_entry || cmd.load_status) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item latch, insertion position and emission index.
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item <= in_data;
    end
    if (cmd.pos_load) begin
      pos <= fill[AW-1:0];
    end else if (cmd.pos_dec) begin
      pos <= pos - AW'(1);
    end
    if (cmd.emit_start) begin
      idx <= '0;
    end else if (cmd.emit_inc) begin
      idx <= idx + AW'(1);
    end
  end

  // Table memory: one read and one write per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (cmd.rd_prev || cmd.emit_rd) begin
      rdata <= mem[rd_addr];
    end
    if (cmd.wr_shift) begin
      mem[pos] <= rdata;
    end else if (cmd.wr_new) begin
      mem[pos] <= new_entry;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      out_data <= '{status: error, entry_count: 7'd0, out_x: 16'd0, out_y: 16'd0,
                    out_climate_a: 32'd0, out_climate_b: 32'd0,
                    out_climate_c: 32'd0, out_climate_d: 32'd0,
                    entry_valid: 1'b0, last_result: 1'b1};
    end else if (cmd.load_entry) begin
      out_data.status        <= ST_OK;
      out_data.entry_count   <= 7'(fill);
      out_data.out_x         <= rdata.key[31:16];
      out_data.out_y         <= rdata.key[15:0];
      out_data.out_climate_a <= rdata.ca;
      out_data.out_climate_b <= rdata.cb;
      out_data.out_climate_c <= rdata.cc;
      out_data.out_climate_d <= rdata.cd;
      out_data.entry_valid   <= 1'b1;
      out_data.last_result   <= sts.emit_last;
    end
  end

  // Flags for the controller.
  always_comb begin
    sts.has_entry = item.has_entry;
    sts.last_item = item.last_item;
    sts.full      = (fill == FW'(TABLE_DEPTH));
    sts.err_set   = (error != ST_OK);
    sts.rsv_bad   = |item.reserved_word;
    sts.clim_bad  = !climate_ok(item.climate_a) || !climate_ok(item.climate_b) ||
                    !climate_ok(item.climate_c) || !climate_ok(item.climate_d);
    sts.fill_zero = (fill == '0);
    sts.pos_one   = (pos == AW'(1));
    sts.cmp_gt    = (rdata.key > key);
    sts.cmp_eq    = (rdata.key == key);
    sts.emit_last = (FW'(idx) == fill - FW'(1));
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

>>> hdl/stb_ctrl.sv
`default_nettype none

module stb_ctrl
  import stb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_CMP,
    S_PLACE,
    S_FINISH,
    S_ERD,
    S_ELD
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    cmd        = '0;
    cmd.err_code = ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_FINISH;
        if (sts.has_entry) begin
          if (sts.full) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_OVERFLOW;
          end else if (sts.err_set) begin
            cmd.fill_inc = 1'b1;
          end else begin
            cmd.fill_inc = 1'b1;
            if (sts.rsv_bad) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_RESERVED;
            end else if (sts.clim_bad) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_CLIMATE;
            end else begin
              cmd.pos_load = 1'b1;
              state_next   = sts.fill_zero ? S_PLACE : S_READ;
            end
          end
        end
      end
      S_READ: begin
        cmd.rd_prev = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        // Larger neighbours move up one place; an equal one rejects the set.
        if (sts.cmp_gt) begin
          cmd.wr_shift = 1'b1;
          cmd.pos_dec  = 1'b1;
          state_next   = sts.pos_one ? S_PLACE : S_READ;
        end else if (sts.cmp_eq) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_DUPLICATE;
          state_next   = S_FINISH;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.wr_new = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.last_item) begin
          state_next = S_IDLE;
        end else if (sts.err_set || sts.fill_zero) begin
          if (sts.out_free) begin
            cmd.load_status = 1'b1;
            cmd.clear_set   = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.emit_start = 1'b1;
          state_next     = S_ERD;
        end
      end
      S_ERD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_ELD;
      end
      S_ELD: begin
        if (sts.out_free) begin
          cmd.load_entry = 1'b1;
          if (sts.emit_last) begin
            cmd.clear_set = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.emit_inc = 1'b1;
            state_next   = S_ERD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/sorted_tile_table_builder.sv
// Sorted tile table builder. Tile records arrive one per input request and
// are insertion-sorted by column, then row, into a table memory with a
// single read port and TABLE_DEPTH entries. A request without a record, a
// record that fails its own checks, a record that meets a full table and any
// record after the set has failed pass from the check state straight to the
// finish state. A record that is stored is compared with every stored entry
// with a larger key and the next smaller one if there is one; each step of
// the insertion scan reads one entry and then writes it one place up, before
// the record itself is written. A record found to be a duplicate ends the
// scan without being written. On the request marked last, the table is then
// read out in order, each entry read and then loaded into the output register
// once the output is free, or a single status-only result is given if the
// set was rejected or empty. No input request is taken while a record is
// inserted or the table is read out. The memory needs no clearing after
// reset.
`default_nettype none

module sorted_tile_table_builder
  import stb_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire item_t   in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing of checks, insertion and read-out.
  stb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table memory, set state and output register.
  stb_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> hdl/stb_checker.sv
`default_nettype none

module stb_checker
  import stb_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire result_t out_data
);

  // A result that is not taken stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result request changed while stalled");

  // A status-only result always closes the set.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.entry_valid |-> out_data.last_result)
    else $error("status-only result not marked last");

  // A rejected set gives no entries and no count.
  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_OK) |->
      !out_data.entry_valid && (out_data.entry_count == 7'd0))
    else $error("rejected set carries entry data");

  // Every entry result belongs to an accepted, non-empty set.
  a_entry_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.entry_valid |->
      (out_data.status == ST_OK) && (out_data.entry_count != 7'd0))
    else $error("entry result with bad status or zero count");

endmodule

bind sorted_tile_table_builder stb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
